// ===== hdl/jtm_pkg.sv =====
package jtm_pkg;

  // command codes
  localparam logic [2:0] FN_TAP_RESET = 3'd0;
  localparam logic [2:0] FN_RUN_IDLE  = 3'd1;
  localparam logic [2:0] FN_LOAD_IR   = 3'd2;
  localparam logic [2:0] FN_ENTER_DR  = 3'd3;
  localparam logic [2:0] FN_SHIFT     = 3'd4;
  localparam logic [2:0] FN_EXIT_DR   = 3'd5;

  // result word kinds
  localparam logic [1:0] KIND_CLOCKED = 2'd0;
  localparam logic [1:0] KIND_HELD    = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // configuration register indexes
  localparam logic CFG_IR_LENGTH = 1'b0;
  localparam logic CFG_IR_EXPECT = 1'b1;

  localparam logic [5:0]  IR_LENGTH_RESET = 6'd10;
  localparam logic [31:0] IR_EXPECT_RESET = 32'h0000_0155;

  localparam int S_TDATA_W = 144;
  localparam int M_TDATA_W = 72;

  // TAP controller states
  localparam logic [3:0] TAP_RESET      = 4'd0;
  localparam logic [3:0] TAP_RUN_IDLE   = 4'd1;
  localparam logic [3:0] TAP_SELECT_IR  = 4'd2;
  localparam logic [3:0] TAP_CAPTURE_IR = 4'd3;
  localparam logic [3:0] TAP_SHIFT_IR   = 4'd4;
  localparam logic [3:0] TAP_EXIT1_IR   = 4'd5;
  localparam logic [3:0] TAP_PAUSE_IR   = 4'd6;
  localparam logic [3:0] TAP_EXIT2_IR   = 4'd7;
  localparam logic [3:0] TAP_UPDATE_IR  = 4'd8;
  localparam logic [3:0] TAP_SELECT_DR  = 4'd9;
  localparam logic [3:0] TAP_CAPTURE_DR = 4'd10;
  localparam logic [3:0] TAP_SHIFT_DR   = 4'd11;
  localparam logic [3:0] TAP_EXIT1_DR   = 4'd12;
  localparam logic [3:0] TAP_PAUSE_DR   = 4'd13;
  localparam logic [3:0] TAP_EXIT2_DR   = 4'd14;
  localparam logic [3:0] TAP_UPDATE_DR  = 4'd15;

  typedef struct packed {
    logic        load;
    logic        step;
  } shift_ctl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        tms;
    logic        tdi;
    logic [3:0]  tap_now;
    logic [63:0] captured;
    logic        fault;
    logic        last;
  } item_t;

  function automatic logic [3:0] tap_step(input logic [3:0] s, input logic tms);
    logic [3:0] n;
    case (s)
      TAP_RESET:      n = tms ? TAP_RESET     : TAP_RUN_IDLE;
      TAP_RUN_IDLE:   n = tms ? TAP_SELECT_DR : TAP_RUN_IDLE;
      TAP_SELECT_IR:  n = tms ? TAP_RESET     : TAP_CAPTURE_IR;
      TAP_CAPTURE_IR: n = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
      TAP_SHIFT_IR:   n = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
      TAP_EXIT1_IR:   n = tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
      TAP_PAUSE_IR:   n = tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
      TAP_EXIT2_IR:   n = tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
      TAP_UPDATE_IR:  n = tms ? TAP_SELECT_DR : TAP_RUN_IDLE;
      TAP_SELECT_DR:  n = tms ? TAP_SELECT_IR : TAP_CAPTURE_DR;
      TAP_CAPTURE_DR: n = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
      TAP_SHIFT_DR:   n = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
      TAP_EXIT1_DR:   n = tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
      TAP_PAUSE_DR:   n = tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
      TAP_EXIT2_DR:   n = tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
      TAP_UPDATE_DR:  n = tms ? TAP_SELECT_DR : TAP_RUN_IDLE;
      default:        n = TAP_RESET;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/jtag_master_sequencer.sv =====
// Output: an accepted command moves the controller out of idle; its first word is then
// registered, and one word follows per cycle while m_tready holds.
// Commands: a new one is taken only after the last word of the previous one; up to
// RESET_CLOCKS + 40 words for an instruction load, up to MAX_SHIFT for a data shift.
// Reset: TAP tracked in test-logic-reset, TDI held high, ir_length 10, ir_expect 0x155.
module jtag_master_sequencer #(
  parameter int RESET_CLOCKS = 5,
  parameter int MAX_SHIFT    = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // shift_value, shift_len, hold_last, check_capture, tdo_levels, zero pad
  input  logic [jtm_pkg::S_TDATA_W-1:0] s_tdata,
  // func
  input  logic [2:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tms_level, tdi_level, tap_now, captured, fault, zero pad
  output logic [jtm_pkg::M_TDATA_W-1:0] m_tdata,
  // kind
  output logic [1:0]                    m_tuser,
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_data
);

  logic [5:0]          ir_length;
  logic [31:0]         ir_expect;
  jtm_pkg::shift_ctl_t shift_ctl;
  jtm_pkg::item_t      item;
  jtm_pkg::item_t      out_item;
  logic                item_valid;
  logic                slot_free;
  logic                tdi_bit;
  logic                miss_bit;
  logic [63:0]         captured_now;
  logic [63:0]         captured_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_length <= jtm_pkg::IR_LENGTH_RESET;
      ir_expect <= jtm_pkg::IR_EXPECT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        jtm_pkg::CFG_IR_LENGTH: ir_length <= cfg_data[5:0];
        jtm_pkg::CFG_IR_EXPECT: ir_expect <= cfg_data;
        default: ;
      endcase
    end
  end

  jtm_shift u_shift (
    .clk           (clk),
    .ctl           (shift_ctl),
    .shift_value   (s_tdata[63:0]),
    .tdo_levels    (s_tdata[136:73]),
    .ir_expect     (ir_expect),
    .tdi_bit       (tdi_bit),
    .miss_bit      (miss_bit),
    .captured_now  (captured_now),
    .captured_step (captured_step)
  );

  jtm_ctrl #(
    .RESET_CLOCKS (RESET_CLOCKS),
    .MAX_SHIFT    (MAX_SHIFT)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (s_tvalid),
    .cmd_ready     (s_tready),
    .func          (s_tuser),
    .shift_len     (s_tdata[70:64]),
    .hold_last     (s_tdata[71]),
    .check_capture (s_tdata[72]),
    .ir_length     (ir_length),
    .tdi_bit       (tdi_bit),
    .miss_bit      (miss_bit),
    .captured_now  (captured_now),
    .captured_step (captured_step),
    .shift_ctl     (shift_ctl),
    .slot_free     (slot_free),
    .item_valid    (item_valid),
    .item          (item)
  );

  // output word register
  assign slot_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (slot_free) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && item_valid) begin
      out_item <= item;
    end
  end

  assign m_tdata = {1'b0, out_item.fault, out_item.captured, out_item.tap_now,
                    out_item.tdi, out_item.tms};
  assign m_tuser = out_item.kind;
  assign m_tlast = out_item.last;

endmodule

// ===== hdl/jtm_shift.sv =====
// serial datapath: TDI bits out of the bottom, TDO compared bit by bit against
// the expected instruction pattern, capture mask grown one bit per shift
module jtm_shift (
  input  logic               clk,
  input  jtm_pkg::shift_ctl_t ctl,
  input  logic [63:0]        shift_value,
  input  logic [63:0]        tdo_levels,
  input  logic [31:0]        ir_expect,
  output logic               tdi_bit,
  output logic               miss_bit,
  output logic [63:0]        captured_now,
  output logic [63:0]        captured_step
);

  logic [63:0] val_sr;
  logic [63:0] tdo_sr;
  logic [63:0] tdo_hold;
  logic [31:0] exp_sr;
  logic [63:0] mask;
  logic [63:0] mask_next;

  assign mask_next = {mask[62:0], 1'b1};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_sr   <= shift_value;
      tdo_sr   <= tdo_levels;
      tdo_hold <= tdo_levels;
      exp_sr   <= ir_expect;
      mask     <= '0;
    end else if (ctl.step) begin
      val_sr <= {1'b0, val_sr[63:1]};
      tdo_sr <= {1'b0, tdo_sr[63:1]};
      exp_sr <= {1'b0, exp_sr[31:1]};
      mask   <= mask_next;
    end
  end

  assign tdi_bit       = val_sr[0];
  assign miss_bit      = tdo_sr[0] ^ exp_sr[0];
  assign captured_now  = tdo_hold & mask;
  assign captured_step = tdo_hold & mask_next;

endmodule

// ===== hdl/jtm_ctrl.sv =====
// command sequencer: TMS walks, bit shifts and the TAP state tracker
module jtm_ctrl #(
  parameter int RESET_CLOCKS = 5,
  parameter int MAX_SHIFT    = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [2:0]          func,
  input  logic [6:0]          shift_len,
  input  logic                hold_last,
  input  logic                check_capture,
  input  logic [5:0]          ir_length,
  input  logic                tdi_bit,
  input  logic                miss_bit,
  input  logic [63:0]         captured_now,
  input  logic [63:0]         captured_step,
  output jtm_pkg::shift_ctl_t shift_ctl,
  input  logic                slot_free,
  output logic                item_valid,
  output jtm_pkg::item_t      item
);

  // longest walk: reset run, one idle tick, then five ticks to shift-IR
  localparam int NAV_W   = RESET_CLOCKS + 6;
  localparam int NCW     = $clog2(NAV_W + 1);
  localparam int CNT_MAX = (MAX_SHIFT > 32) ? MAX_SHIFT : 32;
  localparam int BCW     = $clog2(CNT_MAX + 1);

  localparam logic [NAV_W-1:0] ONES_RC    = NAV_W'((1 << RESET_CLOCKS) - 1);
  localparam logic [NAV_W-1:0] SEQ_ZERO   = '0;
  localparam logic [NAV_W-1:0] SEQ_IR     = NAV_W'(6);
  localparam logic [NAV_W-1:0] SEQ_IR_UPD = NAV_W'(12);
  localparam logic [NAV_W-1:0] SEQ_IR_FAR = ONES_RC | NAV_W'(6 << (RESET_CLOCKS + 1));
  localparam logic [NAV_W-1:0] SEQ_DR_UPD = NAV_W'(1);
  localparam logic [NAV_W-1:0] SEQ_DR     = NAV_W'(4);
  localparam logic [NAV_W-1:0] SEQ_EXIT   = NAV_W'(3);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_NAV    = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_REFUSE = 4'b1000
  } st_t;

  st_t              st, st_next;
  logic [3:0]       tap, tap_next;
  logic             tdi_pin, tdi_pin_next;
  logic [NAV_W-1:0] tms_sr, tms_sr_next;
  logic [NCW-1:0]   nav_cnt, nav_cnt_next;
  logic [BCW-1:0]   bit_cnt, bit_cnt_next;
  logic             hold_q, hold_next;
  logic             check_q, check_next;
  logic             post_q, post_next;
  logic             shift_after, shift_after_next;
  logic             miss_q, miss_next;

  logic             fire;
  logic             near_upd;
  logic             near_idle;
  logic [BCW-1:0]   ir_n;
  logic [BCW-1:0]   dr_n;
  logic             final_bit;
  logic             held;
  logic             miss_now;
  logic             ends;

  assign near_upd  = (tap == jtm_pkg::TAP_UPDATE_IR) || (tap == jtm_pkg::TAP_UPDATE_DR);
  assign near_idle = (tap == jtm_pkg::TAP_RESET) || (tap == jtm_pkg::TAP_RUN_IDLE);

  assign ir_n = (ir_length == 6'd0) ? BCW'(1) :
                (ir_length > 6'd32) ? BCW'(32) : BCW'(ir_length);
  assign dr_n = (shift_len > 7'(MAX_SHIFT)) ? BCW'(MAX_SHIFT) : BCW'(shift_len);

  assign item_valid = (st != ST_IDLE);
  assign cmd_ready  = (st == ST_IDLE);
  assign fire       = item_valid && slot_free;

  assign final_bit = (bit_cnt == BCW'(1));
  assign held      = final_bit && hold_q;
  assign miss_now  = miss_q || (check_q && miss_bit);
  assign ends      = final_bit && (!post_q || miss_now);

  always_comb begin
    st_next          = st;
    tap_next         = tap;
    tdi_pin_next     = tdi_pin;
    tms_sr_next      = tms_sr;
    nav_cnt_next     = nav_cnt;
    bit_cnt_next     = bit_cnt;
    hold_next        = hold_q;
    check_next       = check_q;
    post_next        = post_q;
    shift_after_next = shift_after;
    miss_next        = miss_q;
    shift_ctl        = '0;
    item             = '0;
    item.tap_now     = tap;

    case (st)
      ST_IDLE: begin
        if (cmd_valid) begin
          shift_ctl.load   = 1'b1;
          miss_next        = 1'b0;
          shift_after_next = 1'b0;
          post_next        = 1'b0;
          check_next       = 1'b0;
          hold_next        = hold_last;
          bit_cnt_next     = dr_n;
          st_next          = ST_NAV;
          case (func)
            jtm_pkg::FN_TAP_RESET: begin
              tms_sr_next  = ONES_RC;
              nav_cnt_next = NCW'(RESET_CLOCKS);
            end
            jtm_pkg::FN_RUN_IDLE: begin
              tms_sr_next  = near_upd ? SEQ_ZERO : ONES_RC;
              nav_cnt_next = near_upd ? NCW'(1) : NCW'(RESET_CLOCKS + 1);
            end
            jtm_pkg::FN_LOAD_IR: begin
              shift_after_next = 1'b1;
              post_next        = 1'b1;
              hold_next        = 1'b1;
              check_next       = check_capture;
              bit_cnt_next     = ir_n;
              if (near_idle) begin
                tms_sr_next  = SEQ_IR;
                nav_cnt_next = NCW'(5);
              end else if (near_upd) begin
                tms_sr_next  = SEQ_IR_UPD;
                nav_cnt_next = NCW'(6);
              end else begin
                tms_sr_next  = SEQ_IR_FAR;
                nav_cnt_next = NCW'(RESET_CLOCKS + 6);
              end
            end
            jtm_pkg::FN_ENTER_DR: begin
              if (near_upd) begin
                tms_sr_next  = SEQ_DR_UPD;
                nav_cnt_next = NCW'(3);
              end else if (near_idle) begin
                tms_sr_next  = SEQ_DR;
                nav_cnt_next = NCW'(5);
              end else begin
                st_next = ST_REFUSE;
              end
            end
            jtm_pkg::FN_SHIFT: begin
              if (((tap == jtm_pkg::TAP_SHIFT_DR) || (tap == jtm_pkg::TAP_SHIFT_IR)) &&
                  (shift_len != 7'd0)) begin
                st_next = ST_SHIFT;
              end else begin
                st_next = ST_REFUSE;
              end
            end
            jtm_pkg::FN_EXIT_DR: begin
              if (tap == jtm_pkg::TAP_SHIFT_DR) begin
                tms_sr_next  = SEQ_EXIT;
                nav_cnt_next = NCW'(2);
              end else begin
                st_next = ST_REFUSE;
              end
            end
            default: begin
              st_next = ST_REFUSE;
            end
          endcase
        end
      end

      ST_NAV: begin
        item.kind    = jtm_pkg::KIND_CLOCKED;
        item.tms     = tms_sr[0];
        item.tdi     = tdi_pin;
        item.tap_now = jtm_pkg::tap_step(tap, tms_sr[0]);
        item.last    = (nav_cnt == NCW'(1)) && !shift_after;
        item.captured = item.last ? captured_now : '0;
        if (fire) begin
          tap_next     = item.tap_now;
          tms_sr_next  = {1'b0, tms_sr[NAV_W-1:1]};
          nav_cnt_next = nav_cnt - NCW'(1);
          if (nav_cnt == NCW'(1)) begin
            st_next = shift_after ? ST_SHIFT : ST_IDLE;
          end
        end
      end

      ST_SHIFT: begin
        item.kind     = held ? jtm_pkg::KIND_HELD : jtm_pkg::KIND_CLOCKED;
        item.tms      = 1'b0;
        item.tdi      = tdi_bit;
        item.tap_now  = held ? tap : jtm_pkg::tap_step(tap, 1'b0);
        item.last     = ends;
        item.fault    = ends && miss_now;
        item.captured = ends ? captured_step : '0;
        if (fire) begin
          shift_ctl.step = 1'b1;
          tdi_pin_next   = tdi_bit;
          tap_next       = item.tap_now;
          bit_cnt_next   = bit_cnt - BCW'(1);
          miss_next      = miss_now;
          if (final_bit) begin
            if (ends) begin
              st_next = ST_IDLE;
            end else begin
              // instruction in: two TMS-high ticks to update-IR
              tms_sr_next      = SEQ_EXIT;
              nav_cnt_next     = NCW'(2);
              shift_after_next = 1'b0;
              st_next          = ST_NAV;
            end
          end
        end
      end

      ST_REFUSE: begin
        item.kind  = jtm_pkg::KIND_STATUS;
        item.fault = 1'b1;
        item.last  = 1'b1;
        if (fire) begin
          st_next = ST_IDLE;
        end
      end

      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_IDLE;
      tap     <= jtm_pkg::TAP_RESET;
      tdi_pin <= 1'b1;
    end else begin
      st      <= st_next;
      tap     <= tap_next;
      tdi_pin <= tdi_pin_next;
    end
  end

  always_ff @(posedge clk) begin
    tms_sr      <= tms_sr_next;
    nav_cnt     <= nav_cnt_next;
    bit_cnt     <= bit_cnt_next;
    hold_q      <= hold_next;
    check_q     <= check_next;
    post_q      <= post_next;
    shift_after <= shift_after_next;
    miss_q      <= miss_next;
  end

endmodule
